>>> sv/flpte_pkg.sv
// ----------------------------------------------------------------------------
// flpte_pkg
// shared codes, entry bit positions and the memory control bundle
// ----------------------------------------------------------------------------
package flpte_pkg;

  localparam int unsigned ENT_W    = 64;
  localparam int unsigned PADDR_W  = 52;
  localparam int unsigned VADDR_W  = 48;
  localparam int unsigned FRAME_W  = 40;
  localparam int unsigned IDX_W    = 9;
  localparam int unsigned FLAGS_W  = 64;

  localparam logic [1:0] REQ_CREATE = 2'd0;
  localparam logic [1:0] REQ_MAP    = 2'd1;
  localparam logic [1:0] REQ_UNMAP  = 2'd2;
  localparam logic [1:0] REQ_XLATE  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNMAPPED = 2'd1;
  localparam logic [1:0] ST_NOPAGE   = 2'd2;
  localparam logic [1:0] ST_OUTSIDE  = 2'd3;

  localparam int unsigned BIT_PRESENT  = 0;
  localparam int unsigned BIT_WRITABLE = 1;
  localparam int unsigned BIT_USER     = 2;
  localparam int unsigned BIT_HUGE     = 7;

  localparam logic [FRAME_W-1:0] BASE_RST = 40'h0_0000_0100;

  typedef struct packed {
    logic rd;
    logic wr;
  } mem_ctl_t;

endpackage

>>> sv/four_level_page_table_engine_unit.sv
// ----------------------------------------------------------------------------
// four_level_page_table_engine_unit
// x86-64 four-level page table engine over a local pool of table pages
// ----------------------------------------------------------------------------
// After reset the engine clears its table store, one entry per cycle,
// with busy high; table_base writes are taken at any time. A request is
// taken on start while busy is low and one result comes back as a
// single-cycle out_valid strobe that cannot be held off; busy is already
// low in the strobe cycle, so the next request can go in then. All work
// goes through one single-port table memory with a registered read, so each
// table level takes a read state (S_RD) and a check state (S_CHK). Map reads
// until the path ends, then allocates and links each new table, then writes
// the leaf; create allocates one page. Rejected requests answer with a
// strobe registered at the accepting edge. A new table page is zeroed with
// a sweep over its 512 entries only once some write has landed in a pool
// page not yet handed out.
module four_level_page_table_engine_unit #(
  parameter int unsigned TABLE_PAGES = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_req_type,
  input  logic [flpte_pkg::PADDR_W-1:0]     in_root_addr,
  input  logic [flpte_pkg::VADDR_W-1:0]     in_virt_addr,
  input  logic [flpte_pkg::PADDR_W-1:0]     in_phys_addr,
  input  logic [flpte_pkg::FLAGS_W-1:0]     in_entry_flags,
  output logic                              out_valid,
  output logic [flpte_pkg::PADDR_W-1:0]     out_addr,
  output logic [1:0]                        out_status,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [flpte_pkg::PADDR_W-1:0]     cfg_table_base
);

  localparam int unsigned PW    = $clog2(TABLE_PAGES);
  localparam int unsigned AW    = PW + flpte_pkg::IDX_W;
  localparam int unsigned DEPTH = TABLE_PAGES * 512;

  logic [flpte_pkg::FRAME_W-1:0] base_r;
  flpte_pkg::mem_ctl_t           mem_ctl;
  logic [AW-1:0]                 mem_addr;
  logic [flpte_pkg::ENT_W-1:0]   mem_wdata;
  logic [flpte_pkg::ENT_W-1:0]   mem_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= flpte_pkg::BASE_RST;
    end else if (cfg_valid && cfg_ready) begin
      base_r <= cfg_table_base[51:12];
    end
  end

  flpte_mem #(
    .AW    (AW),
    .DEPTH (DEPTH)
  ) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  flpte_walk #(
    .TABLE_PAGES (TABLE_PAGES),
    .PW          (PW),
    .AW          (AW)
  ) u_walk (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_root_addr   (in_root_addr),
    .in_virt_addr   (in_virt_addr),
    .in_phys_addr   (in_phys_addr),
    .in_entry_flags (in_entry_flags),
    .base_i         (base_r),
    .mem_ctl        (mem_ctl),
    .mem_addr       (mem_addr),
    .mem_wdata      (mem_wdata),
    .mem_rdata      (mem_rdata),
    .out_valid      (out_valid),
    .out_addr       (out_addr),
    .out_status     (out_status)
  );

endmodule

>>> sv/flpte_mem.sv
// ----------------------------------------------------------------------------
// flpte_mem
// single-port table store, one 64-bit entry per address, registered read
// ----------------------------------------------------------------------------
module flpte_mem #(
  parameter int unsigned AW    = 15,
  parameter int unsigned DEPTH = 32768
) (
  input  logic                           clk,
  input  flpte_pkg::mem_ctl_t            ctl,
  input  logic [AW-1:0]                  addr,
  input  logic [flpte_pkg::ENT_W-1:0]    wdata,
  output logic [flpte_pkg::ENT_W-1:0]    rdata
);

  logic [flpte_pkg::ENT_W-1:0] mem [DEPTH];
  logic [flpte_pkg::ENT_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/flpte_walk.sv
// ----------------------------------------------------------------------------
// flpte_walk
// request sequencer: table walk, page allocation, entry writes, results
// ----------------------------------------------------------------------------
module flpte_walk #(
  parameter int unsigned TABLE_PAGES = 64,
  parameter int unsigned PW          = 6,
  parameter int unsigned AW          = 15
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_req_type,
  input  logic [flpte_pkg::PADDR_W-1:0]     in_root_addr,
  input  logic [flpte_pkg::VADDR_W-1:0]     in_virt_addr,
  input  logic [flpte_pkg::PADDR_W-1:0]     in_phys_addr,
  input  logic [flpte_pkg::FLAGS_W-1:0]     in_entry_flags,
  input  logic [flpte_pkg::FRAME_W-1:0]     base_i,
  output flpte_pkg::mem_ctl_t               mem_ctl,
  output logic [AW-1:0]                     mem_addr,
  output logic [flpte_pkg::ENT_W-1:0]       mem_wdata,
  input  logic [flpte_pkg::ENT_W-1:0]       mem_rdata,
  output logic                              out_valid,
  output logic [flpte_pkg::PADDR_W-1:0]     out_addr,
  output logic [1:0]                        out_status
);

  localparam int unsigned DEPTH = TABLE_PAGES * 512;
  localparam int unsigned FW    = flpte_pkg::FRAME_W;
  localparam int unsigned IW    = flpte_pkg::IDX_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [IW-1:0] LAST_IDX  = {IW{1'b1}};
  localparam logic [PW:0]   PAGES_N   = (PW+1)'(TABLE_PAGES);
  localparam logic [PW+1:0] PAGES_W   = (PW+2)'(TABLE_PAGES);
  localparam logic [FW-1:0] POOL_N    = FW'(TABLE_PAGES);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_CHK   = 4'd3;
  localparam logic [3:0] S_ALLOC = 4'd4;
  localparam logic [3:0] S_ZERO  = 4'd5;
  localparam logic [3:0] S_POST  = 4'd6;
  localparam logic [3:0] S_LEAF  = 4'd7;
  localparam logic [3:0] S_UNMAP = 4'd8;

  logic [3:0]                     state_r, state_nxt;
  logic [AW-1:0]                  cnt_r, cnt_nxt;
  logic [1:0]                     lv_r, lv_nxt;
  logic [PW-1:0]                  cur_r, cur_nxt;
  logic [PW-1:0]                  alloc_r, alloc_nxt;
  logic [PW:0]                    nfree_r, nfree_nxt;
  logic                           dirty_r, dirty_nxt;
  logic [1:0]                     req_r, req_nxt;
  logic [flpte_pkg::VADDR_W-1:0]  va_r, va_nxt;
  logic [FW-1:0]                  pa_r, pa_nxt;
  logic [flpte_pkg::FLAGS_W-1:0]  flags_r, flags_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [flpte_pkg::PADDR_W-1:0]  out_addr_r, out_addr_nxt;
  logic [1:0]                     out_status_r, out_status_nxt;

  logic [IW-1:0]                  idx;
  logic [FW-1:0]                  root_off;
  logic [FW-1:0]                  e_off;
  logic                           root_hit;
  logic                           e_hit;
  logic                           e_present;
  logic [FW-1:0]                  alloc_addr;
  logic [PW+1:0]                  need_sum;

  always_comb begin
    case (lv_r)
      2'd0:    idx = va_r[47:39];
      2'd1:    idx = va_r[38:30];
      2'd2:    idx = va_r[29:21];
      default: idx = va_r[20:12];
    endcase
  end

  assign root_off   = in_root_addr[51:12] - base_i;
  assign root_hit   = root_off < POOL_N;
  assign e_off      = mem_rdata[51:12] - base_i;
  assign e_hit      = e_off < POOL_N;
  assign e_present  = mem_rdata[flpte_pkg::BIT_PRESENT];
  assign alloc_addr = base_i + FW'(alloc_r);
  assign need_sum   = {1'b0, nfree_r} + (PW+2)'(2'd3 - lv_r);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    lv_nxt         = lv_r;
    cur_nxt        = cur_r;
    alloc_nxt      = alloc_r;
    nfree_nxt      = nfree_r;
    dirty_nxt      = dirty_r;
    req_nxt        = req_r;
    va_nxt         = va_r;
    pa_nxt         = pa_r;
    flags_nxt      = flags_r;
    out_valid_nxt  = 1'b0;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    mem_ctl        = '0;
    mem_addr       = {cur_r, idx};
    mem_wdata      = '0;

    case (state_r)
      S_CLEAR: begin
        mem_ctl.wr = 1'b1;
        mem_addr   = cnt_r;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_req_type;
          va_nxt    = in_virt_addr;
          pa_nxt    = in_phys_addr[51:12];
          flags_nxt = in_entry_flags;
          lv_nxt    = 2'd0;
          cur_nxt   = root_off[PW-1:0];
          if (in_req_type == flpte_pkg::REQ_CREATE) begin
            if (nfree_r == PAGES_N) begin
              out_valid_nxt  = 1'b1;
              out_addr_nxt   = '0;
              out_status_nxt = flpte_pkg::ST_NOPAGE;
            end else begin
              state_nxt = S_ALLOC;
            end
          end else if (!root_hit) begin
            out_valid_nxt  = 1'b1;
            out_addr_nxt   = '0;
            out_status_nxt = flpte_pkg::ST_OUTSIDE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        mem_ctl.rd = 1'b1;
        state_nxt  = S_CHK;
      end
      S_CHK: begin
        if (req_r == flpte_pkg::REQ_MAP) begin
          if (!e_present) begin
            if (need_sum > PAGES_W) begin
              state_nxt      = S_IDLE;
              out_valid_nxt  = 1'b1;
              out_addr_nxt   = '0;
              out_status_nxt = flpte_pkg::ST_NOPAGE;
            end else begin
              state_nxt = S_ALLOC;
            end
          end else if (!e_hit) begin
            state_nxt      = S_IDLE;
            out_valid_nxt  = 1'b1;
            out_addr_nxt   = '0;
            out_status_nxt = flpte_pkg::ST_OUTSIDE;
          end else begin
            cur_nxt   = e_off[PW-1:0];
            lv_nxt    = lv_r + 2'd1;
            state_nxt = (lv_r == 2'd2) ? S_LEAF : S_RD;
          end
        end else if (lv_r == 2'd3) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (e_present) begin
            out_addr_nxt   = {mem_rdata[51:12], va_r[11:0]};
            out_status_nxt = flpte_pkg::ST_OK;
          end else begin
            out_addr_nxt   = '0;
            out_status_nxt = flpte_pkg::ST_UNMAPPED;
          end
        end else if (!e_present) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = '0;
          out_status_nxt = flpte_pkg::ST_UNMAPPED;
        end else if (req_r == flpte_pkg::REQ_XLATE && lv_r == 2'd2 &&
                     mem_rdata[flpte_pkg::BIT_HUGE]) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = {mem_rdata[51:21], va_r[20:0]};
          out_status_nxt = flpte_pkg::ST_OK;
        end else if (!e_hit) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = '0;
          out_status_nxt = flpte_pkg::ST_OUTSIDE;
        end else begin
          cur_nxt = e_off[PW-1:0];
          lv_nxt  = lv_r + 2'd1;
          if (lv_r == 2'd2 && req_r == flpte_pkg::REQ_UNMAP) begin
            state_nxt = S_UNMAP;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_ALLOC: begin
        alloc_nxt = nfree_r[PW-1:0];
        nfree_nxt = nfree_r + 1'b1;
        cnt_nxt   = '0;
        state_nxt = dirty_r ? S_ZERO : S_POST;
      end
      S_ZERO: begin
        mem_ctl.wr = 1'b1;
        mem_addr   = {alloc_r, cnt_r[IW-1:0]};
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r[IW-1:0] == LAST_IDX) begin
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        if (req_r == flpte_pkg::REQ_CREATE) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = {alloc_addr, 12'h000};
          out_status_nxt = flpte_pkg::ST_OK;
        end else begin
          mem_ctl.wr = 1'b1;
          mem_wdata  = {12'h000, alloc_addr, 12'h000};
          mem_wdata[flpte_pkg::BIT_PRESENT]  = 1'b1;
          mem_wdata[flpte_pkg::BIT_WRITABLE] = 1'b1;
          mem_wdata[flpte_pkg::BIT_USER]     = flags_r[flpte_pkg::BIT_USER];
          if ({1'b0, cur_r} >= nfree_r) begin
            dirty_nxt = 1'b1;
          end
          cur_nxt   = alloc_r;
          lv_nxt    = lv_r + 2'd1;
          state_nxt = (lv_r == 2'd2) ? S_LEAF : S_ALLOC;
        end
      end
      S_LEAF: begin
        mem_ctl.wr = 1'b1;
        mem_wdata  = {12'h000, pa_r, 12'h000} | flags_r;
        mem_wdata[flpte_pkg::BIT_PRESENT] = 1'b1;
        if ({1'b0, cur_r} >= nfree_r) begin
          dirty_nxt = 1'b1;
        end
        state_nxt      = S_IDLE;
        out_valid_nxt  = 1'b1;
        out_addr_nxt   = '0;
        out_status_nxt = flpte_pkg::ST_OK;
      end
      S_UNMAP: begin
        mem_ctl.wr     = 1'b1;
        state_nxt      = S_IDLE;
        out_valid_nxt  = 1'b1;
        out_addr_nxt   = '0;
        out_status_nxt = flpte_pkg::ST_OK;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      nfree_r     <= '0;
      dirty_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      nfree_r     <= nfree_nxt;
      dirty_r     <= dirty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lv_r         <= lv_nxt;
    cur_r        <= cur_nxt;
    alloc_r      <= alloc_nxt;
    req_r        <= req_nxt;
    va_r         <= va_nxt;
    pa_r         <= pa_nxt;
    flags_r      <= flags_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy       = (state_r != S_IDLE) || !rst_n;
  assign out_valid  = out_valid_r;
  assign out_addr   = out_addr_r;
  assign out_status = out_status_r;

  a_nfree_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nfree_r <= PAGES_N)
    else $error("page allocator beyond pool");

  a_nfree_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && nfree_r != $past(nfree_r)) |-> nfree_r == $past(nfree_r) + 1'b1)
    else $error("page allocator moved by more than one");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mem_ctl.wr)
    else $error("table write while idle");

  a_result_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result strobe while request in flight");

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != flpte_pkg::ST_OK) |-> (out_addr_r == '0))
    else $error("failed request returned an address");

endmodule
